### hdl/ucpe_pkg.sv
// ---------------------------------------------------------------------------
// ucpe_pkg: shared types and constants for the code point encoder
// Encoding codes, command codes, queue entry layout and register map.
// ---------------------------------------------------------------------------
package ucpe_pkg;

  typedef enum logic [1:0] {
    ENC_UTF8    = 2'd0,
    ENC_UTF16LE = 2'd1,
    ENC_UTF32LE = 2'd2,
    ENC_NONE    = 2'd3
  } encoding_e;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_ENCODE = 1'b1
  } cmd_e;

  // APB register map
  localparam int unsigned PADDR_W            = 2;
  localparam int unsigned PDATA_W            = 32;
  localparam logic [PADDR_W-1:0] REG_ENC_ADDR = 2'd0;

  // work queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // code point limits
  localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
  localparam logic [31:0] SURR_LO    = 32'h0000_D800;
  localparam logic [31:0] SURR_HI    = 32'h0000_DFFF;
  localparam logic [31:0] CP_1B_END  = 32'h0000_0080;
  localparam logic [31:0] CP_2B_END  = 32'h0000_0800;
  localparam logic [31:0] CP_3B_END  = 32'h0001_0000;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [5:0]  LO_SURR_HI = 6'b110111;   // top bits of 0xDC00
  localparam logic [7:0]  BOM_B0     = 8'hFF;
  localparam logic [7:0]  BOM_B1     = 8'hFE;

  // one classified item: bytes in stream order, index of final byte, error
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            err;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### hdl/unicode_code_point_encoder_core.sv
// ---------------------------------------------------------------------------
// unicode_code_point_encoder_core: code point to UTF-8/16LE/32LE byte stream
// Front classifier, short work queue and byte-serial back end with APB
// configuration of the output encoding.
// ---------------------------------------------------------------------------
// Each input word is either a start command (tuser 0), which emits the
// byte-order mark of the chosen encoding (none for UTF-8, FF FE for UTF-16LE,
// FF FE 00 00 for UTF-32LE), or a code point (tuser 1), which emits its
// encoded bytes, one output word per byte, tlast on the final byte of the
// input word. An invalid UTF-8 code point (above 0x10FFFF or a surrogate)
// gives one output word with tuser (error) and tlast set and tdata 0.
// Encoding mode 3 swallows every input word. Rate: the output carries one
// byte per cycle while m_axis_tready does not stall it, so an input word
// holds the back end for its 1 to 4 bytes; words with no bytes cost nothing there.
// Input words are taken every cycle while the queue (QueueDepth entries) has
// room, so a word can enter while earlier bytes are still draining. With the
// back end free, an accepted word is written into the queue and its first byte
// then moves into the output register. Change encoding_mode only while the block is idle.
// ---------------------------------------------------------------------------
module unicode_code_point_encoder_core #(
  parameter int unsigned QueueDepth = ucpe_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ucpe_pkg::PADDR_W-1:0]  paddr,
  input  logic [ucpe_pkg::PDATA_W-1:0]  pwdata,
  output logic [ucpe_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // [31:0] code_point
  input  logic                          s_axis_tuser,  // [0] cmd
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] out_byte
  output logic                          m_axis_tlast,  // last
  output logic                          m_axis_tuser   // [0] error
);
  import ucpe_pkg::*;

  encoding_e mode_q, mode_d;
  logic      cfg_wr;
  logic      push, pop;
  entry_t    push_entry, head_entry;
  qstat_t    q_stat;

  // --- configuration register: encoding_mode at byte address 0 ---
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_ENC_ADDR);
  assign mode_d = cfg_wr ? encoding_e'(pwdata[1:0]) : mode_q;
  assign prdata = (paddr == REG_ENC_ADDR) ? {{(PDATA_W-2){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ENC_UTF8;
    end else begin
      mode_q <= mode_d;
    end
  end

  // --- front: take word, classify into byte list ---
  ucpe_front u_front (
    .mode_i       (mode_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .code_point_i (s_axis_tdata),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // --- queue: decouples input stalls from output stalls ---
  ucpe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .stat_o  (q_stat)
  );

  // --- back: one byte per cycle into the output register unless the output stalls ---
  ucpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_entry),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

  // --- checks ---
  // an error word always closes its item
  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("error word without tlast");

  // an error word carries a zero byte
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'd0))
    else $error("error word with non-zero byte");

  // a full queue means the back end already holds a word
  a_full_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> m_axis_tvalid)
    else $error("queue full while output register idle");

endmodule

### hdl/ucpe_front.sv
// ---------------------------------------------------------------------------
// ucpe_front: input side of the encoder
// Accepts words, classifies them and turns them into queue entries.
// ---------------------------------------------------------------------------
module ucpe_front (
  input  ucpe_pkg::encoding_e mode_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [31:0]         code_point_i,
  input  ucpe_pkg::qstat_t    q_stat_i,
  output logic                push_o,
  output ucpe_pkg::entry_t    entry_o
);
  import ucpe_pkg::*;

  logic        has_res;
  logic        invalid;
  logic [15:0] hi_unit;
  logic [9:0]  plane_m1;

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && in_ready_o && has_res;

  assign invalid = (code_point_i > CP_MAX) ||
                   ((code_point_i >= SURR_LO) && (code_point_i <= SURR_HI));

  // v = cp - 0x10000 only alters bits 16 and up; v[25:10] is all we need
  assign plane_m1 = code_point_i[25:16] - 10'd1;
  assign hi_unit  = {plane_m1, code_point_i[15:10]} + HI_SURR;

  always_comb begin
    entry_o = '0;
    has_res = 1'b0;
    unique case (mode_i)
      ENC_UTF8: begin
        if (cmd_i == CMD_ENCODE) begin
          has_res = 1'b1;
          if (invalid) begin
            entry_o.err = 1'b1;
          end else if (code_point_i < CP_1B_END) begin
            entry_o.bytes[0] = {1'b0, code_point_i[6:0]};
          end else if (code_point_i < CP_2B_END) begin
            entry_o.bytes[0] = {3'b110, code_point_i[10:6]};
            entry_o.bytes[1] = {2'b10, code_point_i[5:0]};
            entry_o.last_idx = 2'd1;
          end else if (code_point_i < CP_3B_END) begin
            entry_o.bytes[0] = {4'b1110, code_point_i[15:12]};
            entry_o.bytes[1] = {2'b10, code_point_i[11:6]};
            entry_o.bytes[2] = {2'b10, code_point_i[5:0]};
            entry_o.last_idx = 2'd2;
          end else begin
            entry_o.bytes[0] = {5'b11110, code_point_i[20:18]};
            entry_o.bytes[1] = {2'b10, code_point_i[17:12]};
            entry_o.bytes[2] = {2'b10, code_point_i[11:6]};
            entry_o.bytes[3] = {2'b10, code_point_i[5:0]};
            entry_o.last_idx = 2'd3;
          end
        end
      end
      ENC_UTF16LE: begin
        has_res = 1'b1;
        if (cmd_i == CMD_START) begin
          entry_o.bytes[0] = BOM_B0;
          entry_o.bytes[1] = BOM_B1;
          entry_o.last_idx = 2'd1;
        end else if (code_point_i[31:16] == 16'd0) begin
          entry_o.bytes[0] = code_point_i[7:0];
          entry_o.bytes[1] = code_point_i[15:8];
          entry_o.last_idx = 2'd1;
        end else begin
          entry_o.bytes[0] = hi_unit[7:0];
          entry_o.bytes[1] = hi_unit[15:8];
          entry_o.bytes[2] = code_point_i[7:0];
          entry_o.bytes[3] = {LO_SURR_HI, code_point_i[9:8]};
          entry_o.last_idx = 2'd3;
        end
      end
      ENC_UTF32LE: begin
        has_res          = 1'b1;
        entry_o.last_idx = 2'd3;
        if (cmd_i == CMD_START) begin
          entry_o.bytes[0] = BOM_B0;
          entry_o.bytes[1] = BOM_B1;
        end else begin
          entry_o.bytes = code_point_i;
        end
      end
      default: begin
        has_res = 1'b0;   // unused mode: word is swallowed
      end
    endcase
  end

endmodule

### hdl/ucpe_fifo.sv
// ---------------------------------------------------------------------------
// ucpe_fifo: short work queue
// Register queue of classified entries; head is visible without a pop.
// ---------------------------------------------------------------------------
module ucpe_fifo #(
  parameter int unsigned Depth = ucpe_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ucpe_pkg::entry_t wdata_i,
  input  logic             pop_i,
  output ucpe_pkg::entry_t rdata_o,
  output ucpe_pkg::qstat_t stat_o
);
  import ucpe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == DepthCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### hdl/ucpe_back.sv
// ---------------------------------------------------------------------------
// ucpe_back: output side of the encoder
// Walks the queue head one byte a cycle, unless the output stalls, into a registered output word.
// ---------------------------------------------------------------------------
module ucpe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ucpe_pkg::entry_t head_i,
  input  ucpe_pkg::qstat_t q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  output logic             out_err_o
);
  import ucpe_pkg::*;

  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  logic [7:0] byte_q;
  logic       last_q, err_q;
  logic       out_adv, take, final_byte;

  assign out_adv    = !valid_q || out_ready_i;
  assign take       = out_adv && !q_stat_i.empty;
  assign final_byte = (idx_q == head_i.last_idx);
  assign pop_o      = take && final_byte;

  always_comb begin
    valid_d = out_adv ? take : valid_q;
    idx_d   = idx_q;
    if (take) begin
      idx_d = final_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= head_i.bytes[idx_q];
      last_q <= final_byte;
      err_q  <= head_i.err;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_err_o   = err_q;

endmodule

### verif/unicode_code_point_encoder_core_tb.sv
// ---------------------------------------------------------------------------
// unicode_code_point_encoder_core_tb: self-checking bench for the encoder
// Drives start and code point words through every encoding, mirrors the
// byte stream in a ledger of expected output words and checks each one.
// ---------------------------------------------------------------------------
module unicode_code_point_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ucpe_pkg::*;

  // one expected output word
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       err;
  } enc_byte_t;

  // Mirrors the encoder: turns each accepted input word into the bytes it
  // must produce and matches output words against them in order.
  class encoded_byte_ledger;
    encoding_e   mode = ENC_UTF8;
    enc_byte_t   expected_bytes[$];
    int unsigned faults = 0;

    function void predict_bytes(cmd_e cmd, logic [31:0] cp);
      logic [7:0]  b [4];
      int          n;
      logic [31:0] v;
      logic [15:0] hi;
      logic [15:0] lo;
      enc_byte_t   item;
      n = 0;
      if (mode == ENC_NONE) return;
      if (cmd == CMD_START) begin
        // byte-order mark; empty for UTF-8
        b[0] = 8'hFF;
        b[1] = 8'hFE;
        b[2] = 8'h00;
        b[3] = 8'h00;
        n = (mode == ENC_UTF16LE) ? 2 : (mode == ENC_UTF32LE) ? 4 : 0;
      end else begin
        case (mode)
          ENC_UTF8: begin
            if (cp > 32'h0010_FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) begin
              // rejected: one error word, data held at zero
              item = '{data: 8'h00, last: 1'b1, err: 1'b1};
              expected_bytes.insert(expected_bytes.size(), item);
              return;
            end
            if (cp < 32'h80) begin
              b[0] = cp[7:0];
              n = 1;
            end else if (cp < 32'h800) begin
              b[0] = {3'b110, cp[10:6]};
              b[1] = {2'b10, cp[5:0]};
              n = 2;
            end else if (cp < 32'h1_0000) begin
              b[0] = {4'b1110, cp[15:12]};
              b[1] = {2'b10, cp[11:6]};
              b[2] = {2'b10, cp[5:0]};
              n = 3;
            end else begin
              b[0] = {5'b11110, cp[20:18]};
              b[1] = {2'b10, cp[17:12]};
              b[2] = {2'b10, cp[11:6]};
              b[3] = {2'b10, cp[5:0]};
              n = 4;
            end
          end
          ENC_UTF16LE: begin
            if (cp <= 32'hFFFF) begin
              b[0] = cp[7:0];
              b[1] = cp[15:8];
              n = 2;
            end else begin
              // surrogate pair, unchecked: wraps in 32 and 16 bits
              v  = cp - 32'h1_0000;
              hi = v[25:10] + 16'hD800;
              lo = {6'b110111, v[9:0]};
              b[0] = hi[7:0];
              b[1] = hi[15:8];
              b[2] = lo[7:0];
              b[3] = lo[15:8];
              n = 4;
            end
          end
          default: begin
            b[0] = cp[7:0];
            b[1] = cp[15:8];
            b[2] = cp[23:16];
            b[3] = cp[31:24];
            n = 4;
          end
        endcase
      end
      for (int k = 0; k < n; k++) begin
        item = '{data: b[k], last: (k == n - 1), err: 1'b0};
        expected_bytes.insert(expected_bytes.size(), item);
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic err);
      enc_byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output word: tdata %02h tlast %0b tuser %0b", data, last, err);
        faults++;
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, data);
        faults++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        faults++;
      end
      if (err !== want.err) begin
        $error("error: expected %0b, got %0b", want.err, err);
        faults++;
      end
    endfunction
  endclass

  // boundary code points, run under UTF-8
  localparam logic [31:0] UTF8_EDGES [14] = '{
    32'h0000_0000, 32'h0000_007F, 32'h0000_0080, 32'h0000_07FF,
    32'h0000_0800, 32'h0000_D7FF, 32'h0000_D800, 32'h0000_DFFF,
    32'h0000_E000, 32'h0000_FFFF, 32'h0001_0000, 32'h0010_FFFF,
    32'h0011_0000, 32'hFFFF_FFFF
  };
  // surrogates on input, pairs and wrap-around under UTF-16LE
  localparam logic [31:0] UTF16_EDGES [4] = '{
    32'h0000_D800, 32'h0001_0000, 32'h0010_FFFF, 32'hFFFF_FFFF
  };
  localparam encoding_e PHASE_MODES [8] = '{
    ENC_UTF8, ENC_UTF16LE, ENC_UTF32LE, ENC_NONE,
    ENC_UTF16LE, ENC_UTF8, ENC_UTF32LE, ENC_UTF8
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [PADDR_W-1:0]  paddr         = '0;
  logic [PDATA_W-1:0]  pwdata        = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;  // [31:0] code_point
  logic                s_axis_tuser  = 1'b0;  // [0] cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;  // [7:0] out_byte
  logic                m_axis_tlast;
  logic                m_axis_tuser;  // [0] error

  encoded_byte_ledger ledger = new();
  int unsigned        burst_left  = 0;
  int unsigned        hold_cycles = 0;  // receiver hold-off request

  unicode_code_point_encoder_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // APB setup then access; leaves the bus idle so back-to-back calls are
  // separated by an idle gap
  task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_ENC_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata    = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write encoding_mode, read it back, update the ledger's copy
  task automatic configure(input encoding_e mode);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, PDATA_W'(mode), rd);
    apb_access(1'b0, '0, rd);
    if (rd !== PDATA_W'(mode)) begin
      $error("encoding_mode: expected %0h, got %0h", mode, rd);
      ledger.faults++;
    end
    ledger.mode = mode;
  endtask

  // Offer one input word and wait for it to be taken. Sender works in
  // bursts; a gap drops tvalid before the word goes out.
  task automatic send_word(input cmd_e cmd, input logic [31:0] cp);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cp;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.predict_bytes(cmd, cp);
    burst_left--;
  endtask

  // Drain: stop offering, wait for every expected word, then allow for
  // words that produce no bytes but may still be in flight.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (ledger.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // weighted towards each UTF-8 length class and the reject ranges
  function automatic logic [31:0] random_code_point();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(32'h0, 32'h7F);
      1:       return $urandom_range(32'h80, 32'h7FF);
      2, 3:    return $urandom_range(32'h800, 32'hFFFF);
      4, 5:    return $urandom_range(32'h1_0000, 32'h10_FFFF);
      6:       return $urandom_range(32'hD800, 32'hDFFF);
      7:       return $urandom_range(32'h11_0000, 32'h1F_FFFF);
      default: return $urandom();
    endcase
  endfunction

  // Receiver: checks each accepted output word, then picks tready from a
  // stall style that is redrawn at random, or holds off on request.
  initial begin : sink
    int unsigned tick;
    int unsigned style;
    tick  = 0;
    style = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        ledger.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      tick++;
      if (tick % 48 == 0) style = $urandom_range(0, 3);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (tick % 5 != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int words;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every boundary per encoding, marks, unused mode
    configure(ENC_UTF8);
    send_word(CMD_START, $urandom());
    foreach (UTF8_EDGES[i]) send_word(CMD_ENCODE, UTF8_EDGES[i]);
    settle();
    configure(ENC_UTF16LE);
    send_word(CMD_START, $urandom());
    foreach (UTF16_EDGES[i]) send_word(CMD_ENCODE, UTF16_EDGES[i]);
    settle();
    configure(ENC_UTF32LE);
    send_word(CMD_START, 32'h0);
    send_word(CMD_ENCODE, 32'hFFFF_FFFF);
    settle();
    configure(ENC_NONE);
    send_word(CMD_START, 32'hFFFF_FFFF);
    send_word(CMD_ENCODE, 32'h41);
    settle();

    // random strings: a mark then code points, the odd stray mark;
    // two phases start under a long receiver hold-off to fill the queue
    foreach (PHASE_MODES[p]) begin
      configure(PHASE_MODES[p]);
      if (p == 1 || p == 5) hold_cycles = 90;
      words = (PHASE_MODES[p] == ENC_NONE) ? 10 : 27;
      send_word(CMD_START, $urandom());
      for (int i = 0; i < words; i++) begin
        if ($urandom_range(0, 11) == 0) send_word(CMD_START, $urandom());
        else send_word(CMD_ENCODE, random_code_point());
      end
      settle();
    end

    if (ledger.faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
hdl/ucpe_pkg.sv
hdl/ucpe_front.sv
hdl/ucpe_fifo.sv
hdl/ucpe_back.sv
hdl/unicode_code_point_encoder_core.sv
verif/unicode_code_point_encoder_core_tb.sv
